/* sv/grmc_pkg.sv */
// Shared types, constants and the sine and step-size functions for the column ray marcher.
package grmc_pkg;

  localparam int MapDim = 32;
  localparam int MapBits = $clog2(MapDim);
  localparam int SineTableBits = 10;
  localparam int MaxMarchSteps = 1024;
  localparam int StepCntW = $clog2(MaxMarchSteps + 1);
  localparam int QueueDepth = 2;

  localparam logic [2:0] RegViewerX = 3'd0;
  localparam logic [2:0] RegViewerY = 3'd1;
  localparam logic [2:0] RegViewAngle = 3'd2;
  localparam logic [2:0] RegFovAngle = 3'd3;
  localparam logic [2:0] RegScreenW = 3'd4;
  localparam logic [2:0] RegScreenH = 3'd5;
  localparam logic [2:0] RegStepCap = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic [11:0] column;
  } item_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkDiv,
    BkMarch,
    BkRead,
    BkHeight,
    BkOut
  } bk_state_e;

  // Q16 sine of a quarter-turn angle, evaluated at elaboration only.
  function automatic logic [16:0] quarter_sine_q16(input logic [13:0] r_in, input logic full);
    logic [63:0] z, z2, t, v;
    z = full ? (64'd16384 << 16) : ({50'd0, r_in} << 16);
    z2 = (z * z) >> 30;
    t = 64'd172272;
    t = 64'd5026995 - ((z2 * t) >> 30);
    t = 64'd85569306 - ((z2 * t) >> 30);
    t = 64'd693598668 - ((z2 * t) >> 30);
    t = 64'd1686629713 - ((z2 * t) >> 30);
    v = (((z * t) >> 30) + 64'd8192) >> 14;
    if (v > 64'd65536) v = 64'd65536;
    return v[16:0];
  endfunction

  // Step magnitude (0.05 * |trig|, Q16) for a quarter-turn offset r.
  function automatic logic [12:0] step_mag(input logic [13:0] r_in, input logic full);
    logic [16:0] s;
    logic [31:0] m;
    s = quarter_sine_q16(r_in, full);
    m = ({15'd0, s} * 32'd3277 + 32'd32768) >> 16;
    return m[12:0];
  endfunction

endpackage

/* sv/grid_ray_march_column_unit.sv */
// Top level of the column ray marcher with its register file.
// A cast word waits in a two-word queue, then is started, runs the angle divide, loads
// the step vector, marches with a step and bounds test, a map memory read and a wall
// test per step, and ends with the wall-height divide; the march of up to 1024 steps
// through the single map port sets the rate. A row word is written when accepted but
// stalls until every earlier cast has finished. A finished result is held in an output
// register, and the next cast starts only once that register is free or being read.
module grid_ray_march_column_unit import grmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [4:0]  row_index_i,
  input  logic [31:0] row_bits_i,
  input  logic [11:0] column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] column_echo_o,
  output logic        left_map_o,
  output logic [9:0]  distance_steps_o,
  output logic [16:0] wall_height_o,
  output logic signed [16:0] wall_top_o,
  output logic [15:0] wall_bottom_o
);
  logic [20:0] vx_q, vy_q;
  logic [15:0] va_q;
  logic [14:0] fov_q;
  logic [11:0] sw_q, sh_q;
  logic [9:0]  cap_q;
  logic        we;
  item_t       item;
  logic        row_we, q_valid, q_pop, back_busy;
  logic [MapBits-1:0] row_addr;
  logic [31:0] row_data;
  logic [11:0] q_col;

  assign pready = 1'b1;
  assign we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= 21'd131072; vy_q <= 21'd131072; va_q <= '0; fov_q <= 15'd10923;
      sw_q <= 12'd800; sh_q <= 12'd600; cap_q <= 10'd200;
    end else if (we) begin
      unique case (paddr[4:2])
        RegViewerX:   vx_q <= pwdata[20:0];
        RegViewerY:   vy_q <= pwdata[20:0];
        RegViewAngle: va_q <= pwdata[15:0];
        RegFovAngle:  fov_q <= pwdata[14:0];
        RegScreenW:   sw_q <= pwdata[11:0];
        RegScreenH:   sh_q <= pwdata[11:0];
        RegStepCap:   cap_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegViewerX:   prdata = {11'd0, vx_q};
      RegViewerY:   prdata = {11'd0, vy_q};
      RegViewAngle: prdata = {16'd0, va_q};
      RegFovAngle:  prdata = {17'd0, fov_q};
      RegScreenW:   prdata = {20'd0, sw_q};
      RegScreenH:   prdata = {20'd0, sh_q};
      RegStepCap:   prdata = {22'd0, cap_q};
      default:      prdata = '0;
    endcase
  end

  assign item = '{kind: kind_i, row_index: row_index_i, row_bits: row_bits_i,
                  column: column_i};

  grmc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i(item),
    .row_we_o(row_we), .row_addr_o(row_addr), .row_data_o(row_data),
    .q_valid_o(q_valid), .q_column_o(q_col), .q_pop_i(q_pop),
    .back_busy_i(back_busy)
  );

  grmc_back u_back (
    .clk_i, .rst_ni, .row_we_i(row_we), .row_addr_i(row_addr), .row_data_i(row_data),
    .q_valid_i(q_valid), .q_column_i(q_col), .q_pop_o(q_pop), .busy_o(back_busy),
    .viewer_x_i(vx_q), .viewer_y_i(vy_q), .view_angle_i(va_q), .fov_angle_i(fov_q),
    .screen_w_i(sw_q), .screen_h_i(sh_q), .step_cap_i(cap_q),
    .out_valid_o, .out_stall_i, .column_echo_o, .left_map_o, .distance_steps_o,
    .wall_height_o, .wall_top_o, .wall_bottom_o
  );
endmodule

/* sv/grmc_front.sv */
// Front end: accepts words, writes map rows, queues cast requests.
module grmc_front import grmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  item_t       in_item_i,
  output logic        row_we_o,
  output logic [MapBits-1:0] row_addr_o,
  output logic [31:0] row_data_o,
  output logic        q_valid_o,
  output logic [11:0] q_column_o,
  input  logic        q_pop_i,
  input  logic        back_busy_i
);
  logic [11:0] col_q [QueueDepth];
  logic [1:0]  cnt_q, cnt_d;
  logic        rd_q, rd_d, wr_q, wr_d;
  logic        acc, push;

  // hold a row word until every earlier cast has finished
  assign in_stall_o = (cnt_q == 2'(QueueDepth)) ||
                      (!in_item_i.kind && (q_valid_o || back_busy_i));
  assign acc = in_valid_i && !in_stall_o;
  assign push = acc && in_item_i.kind;
  assign row_we_o = acc && !in_item_i.kind && ({1'b0, in_item_i.row_index} < 6'(MapDim));
  assign row_addr_o = in_item_i.row_index[MapBits-1:0];
  assign row_data_o = in_item_i.row_bits;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_column_o = col_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
    rd_d = q_pop_i ? ~rd_q : rd_q;
    wr_d = push ? ~wr_q : wr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) col_q[wr_q] <= in_item_i.column;
  end
endmodule

/* sv/grmc_back.sv */
// Back end: angle divide, ray march over the map memory, wall slice divide.
module grmc_back import grmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        row_we_i,
  input  logic [MapBits-1:0] row_addr_i,
  input  logic [31:0] row_data_i,
  input  logic        q_valid_i,
  input  logic [11:0] q_column_i,
  output logic        q_pop_o,
  output logic        busy_o,
  input  logic [20:0] viewer_x_i,
  input  logic [20:0] viewer_y_i,
  input  logic [15:0] view_angle_i,
  input  logic [14:0] fov_angle_i,
  input  logic [11:0] screen_w_i,
  input  logic [11:0] screen_h_i,
  input  logic [9:0]  step_cap_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] column_echo_o,
  output logic        left_map_o,
  output logic [9:0]  distance_steps_o,
  output logic [16:0] wall_height_o,
  output logic signed [16:0] wall_top_o,
  output logic [15:0] wall_bottom_o
);
  localparam int Shift = 16 - SineTableBits;
  localparam int PosW = 24;
  localparam int TabBits = SineTableBits - 2;
  localparam int TabLen = 1 << TabBits;
  localparam logic [12:0] StepFull = step_mag(14'd0, 1'b1);

  logic [31:0] map_mem [MapDim];
  logic [31:0] rd_data_q;

  bk_state_e st_q, st_d;
  logic [11:0] col_q, col_d;
  logic [26:0] num_q, num_d;   // fov*column dividend / quotient shifter
  logic [12:0] rem_q, rem_d;
  logic [4:0]  bit_q, bit_d;
  logic signed [PosW-1:0] px_q, px_d, py_q, py_d;
  logic signed [13:0] dx_q, dx_d, dy_q, dy_d;
  logic [StepCntW-1:0] stp_q, stp_d;
  logic left_q, left_d;
  logic [9:0] dist_q, dist_d;
  logic [16:0] hq_q, hq_d;
  logic [16:0] ht_q, ht_d;
  logic [MapBits-1:0] cx_q, cx_d, cy_q, cy_d;
  logic ov_q, ov_d;

  logic [11:0] width;
  logic [13:0] trial;
  logic [17:0] htrial;
  logic [15:0] angle, phase;
  logic signed [PosW-1:0] nx, ny;
  logic outside;
  logic [9:0] cap;
  logic [StepCntW-1:0] capw;
  logic [10:0] hs;

  wire  [12:0] step_tab [TabLen];
  logic [15:0] phase_c;
  logic [13:0] rs, rc;
  logic        fs, fc;
  logic [12:0] ms, mc;
  logic signed [13:0] dx_w, dy_w;

  // constant quarter-turn step table, one entry per table angle
  for (genvar k = 0; k < TabLen; k++) begin : g_step_tab
    assign step_tab[k] = step_mag(14'(k << Shift), 1'b0);
  end

  always_comb begin
    phase_c = phase + 16'd16384;
    rs = phase[14] ? (14'd0 - phase[13:0]) : phase[13:0];
    fs = phase[14] && (phase[13:0] == 14'd0);
    rc = phase_c[14] ? (14'd0 - phase_c[13:0]) : phase_c[13:0];
    fc = phase_c[14] && (phase_c[13:0] == 14'd0);
    ms = fs ? StepFull : step_tab[rs[13 -: TabBits]];
    mc = fc ? StepFull : step_tab[rc[13 -: TabBits]];
    dy_w = phase[15] ? -$signed({1'b0, ms}) : $signed({1'b0, ms});
    dx_w = phase_c[15] ? -$signed({1'b0, mc}) : $signed({1'b0, mc});
  end

  always_ff @(posedge clk_i) begin
    if (row_we_i) map_mem[row_addr_i] <= row_data_i;
    rd_data_q <= map_mem[cy_q];
  end

  assign busy_o = (st_q != BkIdle);

  always_comb begin
    st_d = st_q; col_d = col_q; num_d = num_q; rem_d = rem_q; bit_d = bit_q;
    px_d = px_q; py_d = py_q; dx_d = dx_q; dy_d = dy_q; stp_d = stp_q;
    left_d = left_q; dist_d = dist_q; hq_d = hq_q; ht_d = ht_q;
    cx_d = cx_q; cy_d = cy_q; ov_d = ov_q; q_pop_o = 1'b0;
    width = (screen_w_i == 12'd0) ? 12'd1 : screen_w_i;
    trial = {rem_q, num_q[26]} - {2'b00, width};
    angle = view_angle_i - {2'b00, fov_angle_i[14:1]} + num_q[15:0];
    phase = (angle >> Shift) << Shift;
    nx = px_q + PosW'(dx_q);
    ny = py_q + PosW'(dy_q);
    outside = nx[PosW-1] || ny[PosW-1] || (nx >= PosW'(MapDim * 65536))
              || (ny >= PosW'(MapDim * 65536));
    cap = (step_cap_i == 10'd0) ? 10'd1 : step_cap_i;
    capw = StepCntW'(cap);
    htrial = {ht_q, hq_q[16]} - {8'd0, dist_q};
    hs = screen_h_i[11:1];
    unique case (st_q)
      BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          col_d = q_column_i;
          num_d = {12'd0, fov_angle_i} * {15'd0, q_column_i};
          rem_d = '0;
          bit_d = 5'd26;
          st_d = BkDiv;
        end
      end
      BkDiv: begin
        // restoring divide, one quotient bit a cycle
        if (!trial[13]) begin
          rem_d = trial[12:0];
          num_d = {num_q[25:0], 1'b1};
        end else begin
          rem_d = {rem_q[11:0], num_q[26]};
          num_d = {num_q[25:0], 1'b0};
        end
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          st_d = BkMarch;
          bit_d = 5'd0;
          px_d = PosW'(viewer_x_i);
          py_d = PosW'(viewer_y_i);
          stp_d = '0;
        end
      end
      BkMarch: begin
        if (stp_q == StepCntW'(0)) begin
          dx_d = dx_w;
          dy_d = dy_w;
          // first real step is taken on the next pass with dx/dy loaded
          stp_d = '0;
          st_d = BkRead;
          ov_d = 1'b1;
        end
      end
      BkRead: begin
        if (ov_q) begin
          // step, then test bounds; issue map read for the new cell
          ov_d = 1'b0;
          px_d = nx; py_d = ny;
          stp_d = stp_q + StepCntW'(1);
          cx_d = nx[16 +: MapBits];
          cy_d = ny[16 +: MapBits];
          if (outside) begin
            left_d = 1'b1;
            st_d = BkHeight;
            ov_d = 1'b1;
          end else begin
            st_d = BkOut;
          end
        end
      end
      BkOut: begin
        // wait state for registered map read
        st_d = BkHeight;
        ov_d = 1'b0;
      end
      BkHeight: begin
        if (!ov_q && bit_q != 5'd31) begin
          // map data arrived (from BkOut path)
          if (rd_data_q[cx_q]) begin
            left_d = 1'b0;
            ov_d = 1'b1;
          end else if (stp_q == StepCntW'(MaxMarchSteps)) begin
            left_d = 1'b1;
            ov_d = 1'b1;
          end else begin
            st_d = BkRead;
            ov_d = 1'b1;
          end
          if (rd_data_q[cx_q] || stp_q == StepCntW'(MaxMarchSteps)) begin
            dist_d = (stp_q < capw) ? stp_q[9:0] : cap;
            hq_d = 17'(20 * screen_h_i);
            ht_d = '0;
            bit_d = 5'd31;
          end
        end else if (ov_q && bit_q != 5'd31) begin
          dist_d = (stp_q < capw) ? stp_q[9:0] : cap;
          hq_d = 17'(20 * screen_h_i);
          ht_d = '0;
          bit_d = 5'd31;
        end else begin
          // restoring divide of 20*H by distance, 17 bits
          if (!htrial[17]) begin
            ht_d = htrial[16:0];
            hq_d = {hq_q[15:0], 1'b1};
          end else begin
            ht_d = {ht_q[15:0], hq_q[16]};
            hq_d = {hq_q[15:0], 1'b0};
          end
          num_d = {num_q[25:0], 1'b0};
          rem_d = rem_q + 13'd1;
          if (rem_q[4:0] == 5'd16) begin
            st_d = BkIdle;
            ov_d = 1'b1;
          end
        end
        if (bit_q != 5'd31 && (ov_d && st_d == BkHeight)) rem_d = '0;
      end
      default: st_d = BkIdle;
    endcase
    // result register handoff
    if (st_q == BkHeight && st_d == BkIdle) st_d = BkIdle;
    if (out_valid_o && out_stall_i && st_q == BkIdle) begin
      st_d = BkIdle; q_pop_o = 1'b0; col_d = col_q; num_d = num_q; rem_d = rem_q;
      bit_d = bit_q;
    end
  end

  logic done, ovl_q;
  assign done = (st_q == BkHeight) && (st_d == BkIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      ovl_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (done) ovl_q <= 1'b1;
      else if (!out_stall_i) ovl_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d; num_q <= num_d; rem_q <= rem_d; bit_q <= bit_d;
    px_q <= px_d; py_q <= py_d; dx_q <= dx_d; dy_q <= dy_d; stp_q <= stp_d;
    left_q <= left_d; dist_q <= dist_d; hq_q <= hq_d; ht_q <= ht_d;
    cx_q <= cx_d; cy_q <= cy_d; ov_q <= ov_d;
    if (done) begin
      column_echo_o <= col_q;
      left_map_o <= left_q;
      distance_steps_o <= dist_q;
      wall_height_o <= hq_d;
      wall_top_o <= $signed({6'd0, hs}) - $signed({1'b0, hq_d[16:1]});
      wall_bottom_o <= 16'({5'd0, hs} + hq_d[16:1]);
    end
  end

  assign out_valid_o = ovl_q;
endmodule
